FILE: sv/keypad_scan_debounce_hold_core_macros.svh
// Assertion macros for the keypad scanner core.
// The macros use the i_clk and i_rst_n names of the module that includes this file.
`ifndef KEYPAD_SCAN_DEBOUNCE_HOLD_CORE_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_HOLD_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define KPSDH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("keypad core assertion failed");
// Next-cycle implication
`define KPSDH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keypad core assertion failed");
`else
`define KPSDH_ASSERT_IMP(lbl, ante, cons)
`define KPSDH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/kpsdh_pkg.sv
package kpsdh_pkg;

    localparam int unsigned KeyW   = 3;
    localparam int unsigned CountW = 16;
    localparam int unsigned ColW   = 3;

    // code for no key pressed
    localparam logic [KeyW-1:0]   KEY_NONE  = 3'd7;
    localparam logic [CountW-1:0] COUNT_MAX = 16'hFFFF;

    // request kinds carried in tuser
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // configuration register indexes
    localparam logic CFG_PRESS = 1'b0;
    localparam logic CFG_HOLD  = 1'b1;

    localparam logic [CountW-1:0] PRESS_RESET = 16'd4;
    localparam logic [CountW-1:0] HOLD_RESET  = 16'd100;

    // latch event from the debouncer
    typedef struct packed {
        logic            fire;
        logic [KeyW-1:0] key;
        logic            is_long;
    } t_latch;

    // priority encoder: row 1 columns first, then row 2; active low
    function automatic logic [KeyW-1:0] encode_key(input logic [ColW-1:0] r1,
                                                   input logic [ColW-1:0] r2);
        logic [KeyW-1:0] k;
        k = KEY_NONE;
        if (!r1[0])      k = 3'd0;
        else if (!r1[1]) k = 3'd1;
        else if (!r1[2]) k = 3'd2;
        else if (!r2[0]) k = 3'd3;
        else if (!r2[1]) k = 3'd4;
        else if (!r2[2]) k = 3'd5;
        return k;
    endfunction

endpackage

FILE: sv/keypad_scan_debounce_hold_core.sv
// Keypad scanner core: 3x2 matrix priority encode, debounce, short/long press latch.
// A read request passes through the input register and then the output register before
// its result can be taken; scan ticks give no result.
// Throughput: one request per cycle; the input stalls only while a read waits behind a
// result held in the output register with m_axis_tready low.
// Reset (synchronous, active low) clears debounce state and latch; press 4, hold 100.
`include "keypad_scan_debounce_hold_core_macros.svh"

module keypad_scan_debounce_hold_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_addr,
    input  logic [kpsdh_pkg::CountW-1:0]        i_cfg_wdata,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // row_one_cols[2:0], row_two_cols[5:3]
    input  logic                                s_axis_tuser,  // req_type
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // key_index[2:0], long_press[3]
    output logic                                m_axis_tuser   // key_valid
);

    logic [kpsdh_pkg::CountW-1:0] r_press_count, r_hold_count;

    logic                         r_in_valid;
    logic                         r_in_req;
    logic [kpsdh_pkg::KeyW-1:0]   r_in_key;

    logic                         r_pend_valid;
    logic [kpsdh_pkg::KeyW-1:0]   r_pend_key;
    logic                         r_pend_long;

    logic                         r_out_valid;
    logic                         r_out_kvalid;
    logic [kpsdh_pkg::KeyW-1:0]   r_out_key;
    logic                         r_out_long;

    logic                         out_free;
    logic                         proc;
    logic                         proc_scan;
    logic                         proc_read;
    kpsdh_pkg::t_latch            evt;

    // handshake between stages
    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && ((r_in_req == kpsdh_pkg::REQ_SCAN) || out_free);
    assign proc_scan     = proc && (r_in_req == kpsdh_pkg::REQ_SCAN);
    assign proc_read     = proc && (r_in_req == kpsdh_pkg::REQ_READ);
    assign s_axis_tready = !r_in_valid || proc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_count <= kpsdh_pkg::PRESS_RESET;
            r_hold_count  <= kpsdh_pkg::HOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                kpsdh_pkg::CFG_PRESS: r_press_count <= i_cfg_wdata;
                kpsdh_pkg::CFG_HOLD:  r_hold_count  <= i_cfg_wdata;
                default:              r_press_count <= r_press_count;
            endcase
        end
    end

    // input register; the key is encoded on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req <= s_axis_tuser;
            r_in_key <= kpsdh_pkg::encode_key(s_axis_tdata[2:0], s_axis_tdata[5:3]);
        end
    end

    kpsdh_debounce u_debounce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_scan        (proc_scan),
        .i_key         (r_in_key),
        .i_press_count (r_press_count),
        .i_hold_count  (r_hold_count),
        .o_evt         (evt)
    );

    // latched key: set by a press event, cleared by a read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_key   <= '0;
            r_pend_long  <= 1'b0;
        end else if (proc_scan && evt.fire) begin
            r_pend_valid <= 1'b1;
            r_pend_key   <= evt.key;
            r_pend_long  <= evt.is_long;
        end else if (proc_read) begin
            r_pend_valid <= 1'b0;
            r_pend_key   <= '0;
            r_pend_long  <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_read) begin
            r_out_kvalid <= r_pend_valid;
            r_out_key    <= r_pend_key;
            r_out_long   <= r_pend_long;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kvalid;
    assign m_axis_tdata  = {4'b0000, r_out_long, r_out_key};

    // checks
    `KPSDH_ASSERT_NXT(a_read_loads_out, proc_read, r_out_valid)
    `KPSDH_ASSERT_NXT(a_read_clears_pend, proc_read, !r_pend_valid)
    `KPSDH_ASSERT_IMP(a_idle_pend_zero, !r_pend_valid, (r_pend_key == '0) && !r_pend_long)
    `KPSDH_ASSERT_IMP(a_out_from_read, $rose(r_out_valid), $past(proc_read))
    `KPSDH_ASSERT_IMP(a_out_key_range, r_out_valid, r_out_key <= 3'd5)

endmodule

FILE: sv/kpsdh_debounce.sv
module kpsdh_debounce (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_scan,
    input  logic [kpsdh_pkg::KeyW-1:0]         i_key,
    input  logic [kpsdh_pkg::CountW-1:0]       i_press_count,
    input  logic [kpsdh_pkg::CountW-1:0]       i_hold_count,
    output kpsdh_pkg::t_latch                  o_evt
);

    logic [kpsdh_pkg::KeyW-1:0]   r_prev_key, n_prev_key;
    logic [kpsdh_pkg::CountW-1:0] r_count,    n_count;

    // next debounce state and latch event for the current tick
    always_comb begin
        n_prev_key    = r_prev_key;
        n_count       = r_count;
        o_evt.fire    = 1'b0;
        o_evt.key     = i_key;
        o_evt.is_long = 1'b0;
        if (i_key == kpsdh_pkg::KEY_NONE) begin
            n_prev_key = '0;
            n_count    = '0;
        end else if (r_count == '0) begin
            n_prev_key = i_key;
            n_count    = 16'd1;
        end else if (i_key != r_prev_key) begin
            n_prev_key = '0;
            n_count    = '0;
        end else if (r_count == kpsdh_pkg::COUNT_MAX) begin
            // saturated
        end else if (r_count == i_press_count) begin
            o_evt.fire = 1'b1;
            n_count    = r_count + 16'd1;
        end else if (r_count == i_hold_count) begin
            o_evt.fire    = 1'b1;
            o_evt.is_long = 1'b1;
            n_count       = r_count + 16'd1;
        end else if (r_count > i_hold_count) begin
            // frozen past the long press
        end else begin
            n_count = r_count + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_key <= '0;
            r_count    <= '0;
        end else if (i_scan) begin
            r_prev_key <= n_prev_key;
            r_count    <= n_count;
        end
    end

endmodule
